// ===== sv/gfm_pkg.sv =====
// Package for the GF(2^128) field multiplier: word types, reduction taps
// and the carry-less multiply and fold functions. No dependencies.
package gfm_pkg;

    localparam int unsigned GFM_HALF_W = 64;
    localparam int unsigned GFM_FULL_W = 2 * GFM_HALF_W;

    // x^128 = x^7 + x^2 + x + 1; the right shifts recover the spilled bits.
    localparam int unsigned GFM_TAP_1 = 1;
    localparam int unsigned GFM_TAP_2 = 2;
    localparam int unsigned GFM_TAP_7 = 7;
    localparam int unsigned GFM_SPILL_1 = GFM_HALF_W - GFM_TAP_1;
    localparam int unsigned GFM_SPILL_2 = GFM_HALF_W - GFM_TAP_2;
    localparam int unsigned GFM_SPILL_7 = GFM_HALF_W - GFM_TAP_7;

    typedef logic [GFM_HALF_W-1:0] gfm_half_t;
    typedef logic [GFM_FULL_W-1:0] gfm_full_t;

    typedef struct packed {
        gfm_half_t a_low;
        gfm_half_t a_high;
        gfm_half_t b_low;
        gfm_half_t b_high;
    } gfm_in_t;

    typedef struct packed {
        gfm_half_t prod_low;
        gfm_half_t prod_high;
    } gfm_out_t;

    // Carry-less 64x64 product; each partial product is independent and
    // the XOR of them maps onto a balanced tree.
    function automatic gfm_full_t gfm_clmul64(input gfm_half_t a, input gfm_half_t b);
        gfm_full_t acc;
        acc = '0;
        for (int i = 0; i < GFM_HALF_W; i++) begin
            if (b[i]) begin
                acc = acc ^ ({{GFM_HALF_W{1'b0}}, a} << i);
            end
        end
        return acc;
    endfunction

    // Fold one word two words down: returns {part for the word one below, part for the word two below}.
    function automatic gfm_full_t gfm_fold_word(input gfm_half_t w);
        gfm_half_t lo_part;
        gfm_half_t hi_part;
        lo_part = w ^ (w << GFM_TAP_1) ^ (w << GFM_TAP_2) ^ (w << GFM_TAP_7);
        hi_part = (w >> GFM_SPILL_1) ^ (w >> GFM_SPILL_2) ^ (w >> GFM_SPILL_7);
        return {hi_part, lo_part};
    endfunction

endpackage

// ===== sv/gfm_mult_core.sv =====
// Combinational Karatsuba carry-less multiply and reduction of one word.
// Depends on gfm_pkg.
module gfm_mult_core
    import gfm_pkg::*;
(
    input  gfm_in_t  op_in,
    output gfm_out_t prod_out
);

    gfm_full_t p_low;
    gfm_full_t p_high;
    gfm_full_t p_mid;
    gfm_full_t mid_term;
    gfm_half_t w0;
    gfm_half_t w1;
    gfm_half_t w2;
    gfm_half_t w3;
    gfm_full_t fold_top;
    gfm_half_t w1_f;
    gfm_half_t w2_f;
    gfm_full_t fold_next;

    assign p_low    = gfm_clmul64(op_in.a_low, op_in.b_low);
    assign p_high   = gfm_clmul64(op_in.a_high, op_in.b_high);
    assign p_mid    = gfm_clmul64(op_in.a_low ^ op_in.a_high, op_in.b_low ^ op_in.b_high);
    assign mid_term = p_mid ^ p_low ^ p_high;

    assign w0 = p_low[GFM_HALF_W-1:0];
    assign w1 = p_low[GFM_FULL_W-1:GFM_HALF_W] ^ mid_term[GFM_HALF_W-1:0];
    assign w2 = p_high[GFM_HALF_W-1:0] ^ mid_term[GFM_FULL_W-1:GFM_HALF_W];
    assign w3 = p_high[GFM_FULL_W-1:GFM_HALF_W];

    // Top word folds into w1 and w2, then the updated w2 folds into w0 and w1.
    assign fold_top  = gfm_fold_word(w3);
    assign w1_f      = w1 ^ fold_top[GFM_HALF_W-1:0];
    assign w2_f      = w2 ^ fold_top[GFM_FULL_W-1:GFM_HALF_W];
    assign fold_next = gfm_fold_word(w2_f);

    assign prod_out.prod_low  = w0 ^ fold_next[GFM_HALF_W-1:0];
    assign prod_out.prod_high = w1_f ^ fold_next[GFM_FULL_W-1:GFM_HALF_W];

endmodule

// ===== sv/gf128_field_multiplier.sv =====
// Top level of the GF(2^128) field multiplier: operand register, multiply
// core and result register. Depends on gfm_pkg and gfm_mult_core.
//
// This block multiplies two elements of GF(2^128), given in plain bit order
// (bit i is the coefficient of x^i) as low and high 64-bit halves, and returns
// the product reduced modulo x^128 + x^7 + x^2 + x + 1. It keeps no state
// between words, so every operand pair is independent. It accepts one word per
// clock cycle and delivers one result word per cycle while the downstream side
// keeps m_ready high. A word passes through the operand register and then the
// result register, with the whole Karatsuba multiply and the two-step reduction
// done combinationally between them. When the result register is stalled, the
// operand register still takes one more word, so at most two words are in
// flight. s_ready depends on m_ready through the operand-register advance.
module gf128_field_multiplier
    import gfm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gfm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output gfm_out_t m_data
);

    logic     op_valid_reg;
    logic     op_valid_next;
    gfm_in_t  op_reg;
    logic     res_valid_reg;
    logic     res_valid_next;
    gfm_out_t res_reg;
    gfm_out_t core_prod;
    logic     res_load;
    logic     op_load;

    // The result register takes a new word whenever it is empty or being drained.
    assign res_load = ~res_valid_reg | m_ready;
    // The operand register can take a word if it is empty or moving on this cycle.
    assign s_ready  = ~op_valid_reg | res_load;
    assign op_load  = s_valid & s_ready;

    gfm_mult_core u_core (
        .op_in    (op_reg),
        .prod_out (core_prod)
    );

    always_comb begin
        op_valid_next  = op_valid_reg;
        res_valid_next = res_valid_reg;
        if (res_load) begin
            res_valid_next = op_valid_reg;
        end
        if (s_ready) begin
            op_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (op_load) begin
            op_reg <= s_data;
        end
        if (res_load && op_valid_reg) begin
            res_reg <= core_prod;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

endmodule

// ===== sv/gfm_checker.sv =====
// Port-level checks for the GF(2^128) field multiplier and the bind that
// attaches them. Depends on gfm_pkg and gf128_field_multiplier.
module gfm_checker
    import gfm_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input gfm_out_t m_data
);

    // A stalled result word holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With nothing waiting at the output, the input side is always open.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output empty");

    // A result that rises in an empty output traces back to an accepted word.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && $past(aresetn) && $past(aresetn, 2)
            |-> $past(s_valid && s_ready, 2))
        else $error("result word without an accepted input word");

endmodule

bind gf128_field_multiplier gfm_checker u_gfm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/gf128_field_multiplier_tb.sv =====
// Testbench for gf128_field_multiplier: drives operand words, predicts each
// reduced GF(2^128) product and checks the result words in order.
// Depends on gfm_pkg and the RTL of gf128_field_multiplier.
module gf128_field_multiplier_tb
    import gfm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_WORDS = 900;
    localparam int unsigned DRAIN_CYCLES = 10;

    // The scoreboard keeps the products still owed by the block. Its own
    // predictor forms the full 256-bit carry-less product bit by bit and then
    // reduces it one bit at a time from the top, which is a different route to
    // the same answer than the fold the RTL uses.
    class product_scoreboard;
        // x^128 + x^7 + x^2 + x + 1
        localparam logic [255:0] FIELD_POLY = (256'd1 << 128) | 256'h87;

        gfm_out_t expected_products[$];
        int unsigned mismatch_count = 0;

        function gfm_out_t gf128_product(gfm_in_t w);
            logic [127:0] a;
            logic [127:0] b;
            logic [255:0] prod;
            gfm_out_t res;
            a = {w.a_high, w.a_low};
            b = {w.b_high, w.b_low};
            prod = '0;
            for (int i = 0; i < 128; i++) begin
                if (b[i]) begin
                    prod = prod ^ ({128'd0, a} << i);
                end
            end
            for (int i = 255; i >= 128; i--) begin
                if (prod[i]) begin
                    prod = prod ^ (FIELD_POLY << (i - 128));
                end
            end
            res.prod_low = prod[63:0];
            res.prod_high = prod[127:64];
            return res;
        endfunction

        function void note_operands(gfm_in_t w);
            expected_products.push_back(gf128_product(w));
        endfunction

        function void check_product(gfm_out_t got);
            gfm_out_t want;
            if (expected_products.size() == 0) begin
                $display("%0t: result word with none expected: low %h high %h",
                         $time, got.prod_low, got.prod_high);
                mismatch_count++;
                return;
            end
            want = expected_products.pop_front();
            if (got.prod_low !== want.prod_low) begin
                $display("%0t: prod_low expected %h actual %h",
                         $time, want.prod_low, got.prod_low);
                mismatch_count++;
            end
            if (got.prod_high !== want.prod_high) begin
                $display("%0t: prod_high expected %h actual %h",
                         $time, want.prod_high, got.prod_high);
                mismatch_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_products.size();
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    gfm_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    gfm_out_t m_data;

    product_scoreboard sb = new();

    // Receiver stall pattern state.
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_phase = 0;

    gf128_field_multiplier u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // The run is cut off after a fixed time far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("gf128_field_multiplier test failed");
        $finish;
    end

    // Both handshakes are sampled at the rising edge, before any of this
    // edge's nonblocking updates land. The input side is noted first, though
    // the block's latency means a word never leaves in the edge it enters.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_operands(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_product(m_data);
            end
        end
    end

    // The receiver moves between modes of random length: always ready,
    // coin-flip ready, a solid stall, and ready only when the phase counter is a multiple of three.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(1, 40);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= 1'b0;
            end
            default: begin
                m_ready <= (stall_phase % 3 == 0);
            end
        endcase
    end

    // Presents one word and holds it until the block takes it. Valid is left
    // high so that a following word goes out back to back.
    task automatic push_operands(input gfm_in_t w);
        s_valid <= 1'b1;
        s_data <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Drops valid for a number of cycles; a zero gap keeps the stream going.
    task automatic idle_sender(input int unsigned cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Holds the sender until every product sent so far has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (sb.pending() != 0);
    endtask

    // Mix of random halves with the corner values of the field: zero, all
    // ones and lone bits, which exercise the reduction taps on their own.
    function automatic gfm_half_t random_half();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return gfm_half_t'(1) << $urandom_range(0, GFM_HALF_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic gfm_in_t make_operands(input gfm_half_t al, input gfm_half_t ah,
                                              input gfm_half_t bl, input gfm_half_t bh);
        gfm_in_t w;
        w.a_low = al;
        w.a_high = ah;
        w.b_low = bl;
        w.b_high = bh;
        return w;
    endfunction

    initial begin
        gfm_in_t directed[$];
        gfm_half_t x127;
        int unsigned burst;
        int unsigned sent;

        x127 = gfm_half_t'(1) << (GFM_HALF_W - 1);

        // Zero times zero, zero against a full operand on either side.
        directed.push_back(make_operands('0, '0, '0, '0));
        directed.push_back(make_operands('0, '0, '1, '1));
        directed.push_back(make_operands('1, '1, '0, '0));
        // The field's one times all ones gives all ones back.
        directed.push_back(make_operands(64'd1, '0, '1, '1));
        directed.push_back(make_operands('1, '1, 64'd1, '0));
        // All ones squared, the heaviest product.
        directed.push_back(make_operands('1, '1, '1, '1));
        // x^64 squared is x^128, which reduces to the tap pattern alone.
        directed.push_back(make_operands('0, 64'd1, '0, 64'd1));
        // x^127 times x spills a single bit past the top.
        directed.push_back(make_operands('0, x127, 64'd2, '0));
        // x^127 squared puts the only bit at the very top of the product.
        directed.push_back(make_operands('0, x127, '0, x127));
        // x^63, the top bit of the low half, squared to x^126.
        directed.push_back(make_operands(x127, '0, x127, '0));
        // Alternating patterns in both halves.
        directed.push_back(make_operands(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                                         64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa));
        directed.push_back(make_operands('1, '0, '0, '1));
        directed.push_back(make_operands('0, '1, '1, '0));
        // Top bits of each half against a fully random element, then the tap pattern against fixed values.
        directed.push_back(make_operands(x127, x127, {$urandom, $urandom}, {$urandom, $urandom}));
        directed.push_back(make_operands(64'h8000_0000_0000_0087, x127, '1, x127));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words go out back to back, then the pipe is drained.
        foreach (directed[i]) begin
            push_operands(directed[i]);
        end
        wait_drained();

        // Random words in bursts, with gaps between them that may be zero. A few times
        // along the way the sender waits for the block to empty before going on.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
                push_operands(make_operands(random_half(), random_half(),
                                            random_half(), random_half()));
                sent++;
            end
            if ($urandom_range(0, 29) == 0) begin
                wait_drained();
            end else if ($urandom_range(0, 3) == 0) begin
                idle_sender(0);
            end else begin
                idle_sender($urandom_range(1, 8));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("gf128_field_multiplier test passed");
        end else begin
            $display("gf128_field_multiplier test failed");
        end
        $finish;
    end

endmodule

// ===== gf128_field_multiplier.f =====
sv/gfm_pkg.sv
sv/gfm_mult_core.sv
sv/gf128_field_multiplier.sv
sv/gfm_checker.sv
tb/sv/gf128_field_multiplier_tb.sv
